[rtl/three_key_debounce_chord_decoder_macros.svh]
// Assertion macros for the three-key debounce and chord decoder checker.
`ifndef THREE_KEY_DEBOUNCE_CHORD_DECODER_MACROS_SVH
`define THREE_KEY_DEBOUNCE_CHORD_DECODER_MACROS_SVH

// Assertion on clk, disabled while arst_n is asserted
`define TKD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Assertion on clk that also holds during reset
`define TKD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tkd_pkg.sv]
// Shared types and constants of the three-key debounce and chord decoder.
`default_nettype none
package tkd_pkg;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE    = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PRESS = 1'd1;

	// Register reset values (ms)
	localparam logic [15:0] DEBOUNCE_RESET    = 16'd20;
	localparam logic [15:0] SHORT_PRESS_RESET = 16'd800;

	// Bit positions in the pressed and edge masks
	localparam int KEY_BACK    = 0;
	localparam int KEY_DOWN    = 1;
	localparam int KEY_UP      = 2;
	localparam int KEY_POWER   = 3;
	localparam int KEY_CONFIRM = 4;

	// Stream widths
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 80;

	// Per-key filter status for the current poll
	typedef struct packed {
		logic stable;   // stable level after this poll
		logic changed;  // stable level changed on this poll
	} key_stat_t;

endpackage
`default_nettype wire

[rtl/tkd_key_filter.sv]
// Debounce filter for one key: raw level history, change timer and stable level.
`default_nettype none
module tkd_key_filter #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  raw,
	input  wire logic [TIME_WIDTH-1:0] now,
	input  wire logic [15:0]           debounce_time,
	output tkd_pkg::key_stat_t         stat
);
	import tkd_pkg::*;

	logic                  last_raw_q;
	logic                  stable_q;
	logic [TIME_WIDTH-1:0] change_time_q;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                  raw_moved;
	logic                  settle;

	// A raw change restarts the timer; an old enough level becomes stable
	always_comb begin
		elapsed   = now - change_time_q;
		raw_moved = raw != last_raw_q;
		settle    = !raw_moved && (raw != stable_q) &&
		            (elapsed >= TIME_WIDTH'(debounce_time));
		stat.changed = settle;
		stat.stable  = settle ? raw : stable_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b0;
			stable_q      <= 1'b0;
			change_time_q <= '0;
		end else if (en) begin
			if (raw_moved) begin
				last_raw_q    <= raw;
				change_time_q <= now;
			end
			stable_q <= stat.stable;
		end
	end

endmodule
`default_nettype wire

[rtl/three_key_debounce_chord_decoder.sv]
// Top level: input register, key filters, chord and hold decode, result register.
//
//  channel  | dir | fields (low bit first)
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | time_ms[31:0], raw_power, raw_down, raw_up
//  m_axis   | out | pressed_mask[3:0], press_edges[4:0], release_edges[3:0],
//           |     | held_time[31:0], power_held_time[31:0]
//  cfg      | in  | index 0 debounce_time, index 1 short_press_limit
//
// One poll per cycle sustained while m_tready is high; a beat passes the input
// register, then the result register. The key state updates as a poll
// moves into the result register. When m_tready is low the result register
// holds and the input register still takes one more beat if it is empty.
// Reset clears all key state, the valid flags and restores both config registers.
`default_nettype none
module three_key_debounce_chord_decoder #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// time_ms[31:0], raw_power[32], raw_down[33], raw_up[34], zero pad
	input  wire logic [tkd_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// pressed_mask[3:0], press_edges[8:4], release_edges[12:9],
	// held_time[44:13], power_held_time[76:45], zero pad
	output logic [tkd_pkg::M_DATA_W-1:0]       m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [tkd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data
);
	import tkd_pkg::*;

	logic [15:0] debounce_time_q;
	logic [15:0] short_press_limit_q;

	logic        v_s1;
	logic [31:0] time_s1;
	logic        rp_s1, rd_s1, ru_s1;
	logic        adv;
	logic        out_free;

	logic [TIME_WIDTH-1:0] now;
	key_stat_t             st_pwr, st_down, st_up;

	logic                  chord_active_q;
	logic [1:0]            nav_prev_q;
	logic [TIME_WIDTH-1:0] power_press_q;
	logic [TIME_WIDTH-1:0] hold_start_q;
	logic                  hold_valid_q;

	logic                  chord;
	logic [1:0]            nav;
	logic [3:0]            pressed;
	logic [4:0]            pe;
	logic [3:0]            re;
	logic                  any_held;
	logic [TIME_WIDTH-1:0] power_press_nx;
	logic [TIME_WIDTH-1:0] hold_start_nx;
	logic [TIME_WIDTH-1:0] release_span;
	logic [TIME_WIDTH-1:0] held;
	logic [TIME_WIDTH-1:0] pheld;

	logic [M_DATA_W-1:0]   res_q;
	logic                  m_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time_q     <= DEBOUNCE_RESET;
			short_press_limit_q <= SHORT_PRESS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:    debounce_time_q     <= cfg_data;
				REG_SHORT_PRESS: short_press_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: result register frees when empty or taken
	assign out_free = !m_valid_q || m_tready;
	assign adv      = v_s1 && out_free;
	assign s_tready = !v_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			time_s1 <= s_tdata[31:0];
			rp_s1   <= s_tdata[32];
			rd_s1   <= s_tdata[33];
			ru_s1   <= s_tdata[34];
		end
	end

	assign now = TIME_WIDTH'(time_s1);

	// Key filters
	tkd_key_filter #(.TIME_WIDTH(TIME_WIDTH)) u_pwr (
		.clk(clk), .arst_n(arst_n), .en(adv), .raw(rp_s1), .now(now),
		.debounce_time(debounce_time_q), .stat(st_pwr)
	);
	tkd_key_filter #(.TIME_WIDTH(TIME_WIDTH)) u_down (
		.clk(clk), .arst_n(arst_n), .en(adv), .raw(rd_s1), .now(now),
		.debounce_time(debounce_time_q), .stat(st_down)
	);
	tkd_key_filter #(.TIME_WIDTH(TIME_WIDTH)) u_up (
		.clk(clk), .arst_n(arst_n), .en(adv), .raw(ru_s1), .now(now),
		.debounce_time(debounce_time_q), .stat(st_up)
	);

	// Chord, nav, power and hold decode
	always_comb begin
		pressed = '0;
		pe      = '0;
		re      = '0;
		nav     = '0;

		chord = st_down.stable && st_up.stable;
		pe[KEY_BACK] = chord && !chord_active_q;
		re[KEY_BACK] = !chord && chord_active_q;
		pressed[KEY_BACK] = chord;

		// nav keys report only outside a chord
		if (st_down.stable && !chord) begin
			pressed[KEY_DOWN] = 1'b1;
			nav[0]            = 1'b1;
			pe[KEY_DOWN]      = st_down.changed;
		end
		re[KEY_DOWN] = st_down.changed && !st_down.stable && nav_prev_q[0];

		if (st_up.stable && !chord) begin
			pressed[KEY_UP] = 1'b1;
			nav[1]          = 1'b1;
			pe[KEY_UP]      = st_up.changed;
		end
		re[KEY_UP] = st_up.changed && !st_up.stable && nav_prev_q[1];

		// power: confirm on a short hold, measured from the old press time
		release_span       = now - power_press_q;
		pressed[KEY_POWER] = st_pwr.stable;
		if (st_pwr.changed && !st_pwr.stable) begin
			pe[KEY_CONFIRM] = release_span < TIME_WIDTH'(short_press_limit_q);
			re[KEY_POWER]   = 1'b1;
		end
		pe[KEY_POWER] = st_pwr.changed && st_pwr.stable;
		power_press_nx = (st_pwr.changed && st_pwr.stable) ? now : power_press_q;

		// hold timer from the first key held
		any_held = st_pwr.stable || st_down.stable || st_up.stable;
		if (!any_held) begin
			hold_start_nx = '0;
		end else if (!hold_valid_q) begin
			hold_start_nx = now;
		end else begin
			hold_start_nx = hold_start_q;
		end
		held  = any_held ? (now - hold_start_nx) : '0;
		pheld = st_pwr.stable ? (now - power_press_nx) : '0;
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chord_active_q <= 1'b0;
			nav_prev_q     <= '0;
			power_press_q  <= '0;
			hold_start_q   <= '0;
			hold_valid_q   <= 1'b0;
		end else if (adv) begin
			chord_active_q <= chord;
			nav_prev_q     <= nav;
			power_press_q  <= power_press_nx;
			hold_start_q   <= hold_start_nx;
			hold_valid_q   <= any_held;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= {3'b000, 32'(pheld), 32'(held), re, pe, pressed};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q;

endmodule
`default_nettype wire

[rtl/tkd_checker.sv]
// Port-level checker for the three-key debounce and chord decoder, with its bind.
`default_nettype none
`include "three_key_debounce_chord_decoder_macros.svh"
module tkd_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tready,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [tkd_pkg::M_DATA_W-1:0]      m_tdata
);
	import tkd_pkg::*;

	logic [3:0] pm;
	logic [3:0] pe_keys;
	logic       confirm;
	logic [3:0] re;

	assign pm      = m_tdata[3:0];
	assign pe_keys = m_tdata[7:4];
	assign confirm = m_tdata[8];
	assign re      = m_tdata[12:9];

	// A stalled result beat holds its payload
	`TKD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled beat changed")

	// Input side stalls only behind a stalled result beat
	`TKD_ASSERT(a_in_stall, !s_tready |-> m_tvalid && !m_tready, "input stalled, no back-pressure")

	// Chord masks both nav keys in the pressed mask
	`TKD_ASSERT(a_chord_excl, m_tvalid && pm[KEY_BACK] |-> !pm[KEY_DOWN] && !pm[KEY_UP], "nav key in chord")

	// No key shows a press and a release edge in one beat
	`TKD_ASSERT(a_edge_excl, m_tvalid |-> (pe_keys & re) == 4'b0000, "press and release together")

	// Confirm only comes with a power release
	`TKD_ASSERT(a_confirm, m_tvalid && confirm |-> re[KEY_POWER] && !pm[KEY_POWER], "confirm, no release")

endmodule

bind three_key_debounce_chord_decoder tkd_checker u_tkd_checker (
	.clk(clk), .arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
